### sv/b74_pkg.sv
package b74_pkg;

    localparam int RADIX       = 74;
    localparam int CHUNK_W     = 16;
    localparam int STEPS       = 64 / CHUNK_W;
    localparam int STEP_W      = $clog2(STEPS);
    localparam int X_W         = 7 + CHUNK_W;
    localparam int RECIP_SHIFT = 29;
    // ceil(2^29 / 74); the quotient estimate is exact or one too high.
    localparam logic [X_W-1:0] RECIP = 23'd7255013;

    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    typedef logic [7:0] alpha_t [0:RADIX-1];

    localparam alpha_t ALPHABET = '{
        "a", "b", "c", "d", "e", "f", "g", "h", "i", "j", "k", "l", "m",
        "n", "o", "p", "q", "r", "s", "t", "u", "v", "w", "x", "y", "z",
        "A", "B", "C", "D", "E", "F", "G", "H", "I", "J", "K", "L", "M",
        "N", "O", "P", "Q", "R", "S", "T", "U", "V", "W", "X", "Y", "Z",
        " ", "(", ")", ".", "+", "-", "*", "/", "?", "<", ">", "_",
        "0", "1", "2", "3", "4", "5", "6", "7", "8", "9"
    };

    typedef struct packed {
        logic               func;
        logic signed [63:0] value_in;
        logic [3:0]         num_digits;
        logic [7:0]         char_in;
        logic               end_of_string;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         char_out;
        logic signed [63:0] value_out;
        logic               error_flag;
        logic               last_result;
    } out_item_t;

    typedef struct packed {
        logic        func;
        logic        neg;
        logic [63:0] value;
        logic [3:0]  count;
        logic        bad;
        logic [6:0]  digit;
        logic        eos;
    } cmd_t;

    function automatic logic [7:0] digit_to_char(input logic [6:0] d, input logic [6:0] rot);
        logic [7:0] s;
        logic [7:0] idx;
        s = {1'b0, d} + {1'b0, rot};
        if (s >= 8'(RADIX))
        begin
            idx = s - 8'(RADIX);
        end
        else
        begin
            idx = s;
        end
        return ALPHABET[idx[6:0]];
    endfunction

    // Returns the unknown-character flag above the rotated digit.
    function automatic logic [7:0] char_to_digit(input logic [7:0] c, input logic [6:0] rot);
        logic       found;
        logic [6:0] pos;
        logic [7:0] d8;
        found = 1'b0;
        pos   = '0;
        for (int i = 0; i < RADIX; i++)
        begin
            if (ALPHABET[i] == c)
            begin
                found = 1'b1;
                pos   = 7'(i);
            end
        end
        if (pos >= rot)
        begin
            d8 = {1'b0, pos} - {1'b0, rot};
        end
        else
        begin
            d8 = {1'b0, pos} + 8'(RADIX) - {1'b0, rot};
        end
        return {~found, d8[6:0]};
    endfunction

endpackage

### sv/b74_front.sv
module b74_front import b74_pkg::*; #(
    parameter int MAX_DIGITS = 10
) (
    input  logic     push,
    input  in_item_t item,
    input  logic [6:0] rot,
    input  logic     fifo_full,
    output logic     full,
    output logic     cmd_push,
    output cmd_t     cmd
);

    logic [3:0] count;
    logic [7:0] dec;

    always_comb
    begin
        count = item.num_digits;
        if (count == 4'd0)
        begin
            count = 4'd1;
        end
        if (count > 4'(MAX_DIGITS))
        begin
            count = 4'(MAX_DIGITS);
        end
    end

    assign dec = char_to_digit(item.char_in, rot);

    assign full     = fifo_full;
    assign cmd_push = push && !fifo_full;

    always_comb
    begin
        cmd.func  = item.func;
        cmd.neg   = item.value_in[63];
        cmd.value = item.value_in;
        cmd.count = count;
        cmd.bad   = dec[7];
        cmd.digit = dec[6:0];
        cmd.eos   = item.end_of_string;
    end

endmodule

### sv/b74_cmd_fifo.sv
module b74_cmd_fifo import b74_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t din,
    output logic full,
    input  logic pop,
    output logic valid,
    output cmd_t dout
);

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full    = (count_reg == 2'd2);
    assign valid   = (count_reg != 2'd0);
    assign dout    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

### sv/b74_back.sv
module b74_back import b74_pkg::*; #(
    parameter int MAX_DIGITS = 10
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [6:0] rot,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_pop,
    output logic       empty,
    input  logic       pop,
    output out_item_t  result
);

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DIV   = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [63:0]       work_reg;
    logic [63:0]       work_next;
    logic [6:0]        rem_reg;
    logic [6:0]        rem_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [IDX_W-1:0]  wr_idx_reg;
    logic [IDX_W-1:0]  wr_idx_next;
    logic [IDX_W-1:0]  emit_idx_reg;
    logic [IDX_W-1:0]  emit_idx_next;
    logic [3:0]        n_reg;
    logic [3:0]        n_next;
    logic [63:0]       acc_reg;
    logic [63:0]       acc_next;
    logic              bad_reg;
    logic              bad_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_item_t         out_reg;
    out_item_t         out_next;
    logic [6:0]        buf_reg [MAX_DIGITS];

    logic              buf_we;
    logic [IDX_W-1:0]  buf_waddr;
    logic [6:0]        buf_wdata;
    logic              out_free;
    logic              load;
    out_item_t         load_val;
    logic [63:0]       acc74;
    logic [63:0]       acc_new;
    logic              bad_new;

    logic [X_W-1:0]     x;
    logic [2*X_W-1:0]   prod;
    logic [CHUNK_W:0]   q_est;
    logic [X_W:0]       qx74;
    logic [X_W:0]       diff;
    logic [CHUNK_W:0]   q;
    logic [X_W:0]       r;

    // One radix-74 long-division step over the top chunk of the working word.
    always_comb
    begin
        x     = {rem_reg, work_reg[63 -: CHUNK_W]};
        prod  = (2*X_W)'(x) * (2*X_W)'(RECIP);
        q_est = prod[RECIP_SHIFT +: CHUNK_W+1];
        qx74  = ((X_W+1)'(q_est) << 6) + ((X_W+1)'(q_est) << 3) + ((X_W+1)'(q_est) << 1);
        diff  = {1'b0, x} - qx74;
        if (diff[X_W])
        begin
            q = q_est - 1'b1;
            r = diff + (X_W+1)'(RADIX);
        end
        else
        begin
            q = q_est;
            r = diff;
        end
    end

    assign acc74    = (acc_reg << 6) + (acc_reg << 3) + (acc_reg << 1) + 64'(cmd.digit);
    assign acc_new  = cmd.bad ? acc_reg : acc74;
    assign bad_new  = bad_reg || cmd.bad;
    assign out_free = !out_valid_reg || pop;

    always_comb
    begin
        state_next     = state_reg;
        work_next      = work_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        wr_idx_next    = wr_idx_reg;
        emit_idx_next  = emit_idx_reg;
        n_next         = n_reg;
        acc_next       = acc_reg;
        bad_next       = bad_reg;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;
        cmd_pop        = 1'b0;
        buf_we         = 1'b0;
        buf_waddr      = wr_idx_reg;
        buf_wdata      = r[6:0];
        load           = 1'b0;
        load_val       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.func == FUNC_DECODE)
                    begin
                        if (cmd.eos)
                        begin
                            load                 = 1'b1;
                            load_val.value_out   = bad_new ? '0 : acc_new;
                            load_val.error_flag  = bad_new;
                            load_val.last_result = 1'b1;
                            acc_next             = '0;
                            bad_next             = 1'b0;
                        end
                        else
                        begin
                            acc_next = acc_new;
                            bad_next = bad_new;
                        end
                    end
                    else if (cmd.neg)
                    begin
                        load                 = 1'b1;
                        load_val.error_flag  = 1'b1;
                        load_val.last_result = 1'b1;
                    end
                    else
                    begin
                        work_next   = cmd.value;
                        n_next      = cmd.count;
                        wr_idx_next = '0;
                        rem_next    = '0;
                        step_next   = '0;
                        state_next  = (cmd.count == 4'd1) ? S_CHECK : S_DIV;
                    end
                end
            end

            S_DIV:
            begin
                work_next = {work_reg[63-CHUNK_W:0], q[CHUNK_W-1:0]};
                rem_next  = r[6:0];
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(STEPS - 1))
                begin
                    buf_we      = 1'b1;
                    rem_next    = '0;
                    wr_idx_next = wr_idx_reg + 1'b1;
                    if (4'(wr_idx_reg) + 4'd1 == n_reg - 4'd1)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end

            S_CHECK:
            begin
                if (work_reg >= 64'(RADIX))
                begin
                    if (out_free)
                    begin
                        load                 = 1'b1;
                        load_val.error_flag  = 1'b1;
                        load_val.last_result = 1'b1;
                        state_next           = S_IDLE;
                    end
                end
                else
                begin
                    buf_we        = 1'b1;
                    buf_waddr     = IDX_W'(n_reg - 4'd1);
                    buf_wdata     = work_reg[6:0];
                    emit_idx_next = IDX_W'(n_reg - 4'd1);
                    state_next    = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    load                 = 1'b1;
                    load_val.char_out    = digit_to_char(buf_reg[emit_idx_reg], rot);
                    load_val.last_result = (emit_idx_reg == '0);
                    if (emit_idx_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg - 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
            out_next       = load_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rem_reg       <= '0;
            step_reg      <= '0;
            wr_idx_reg    <= '0;
            emit_idx_reg  <= '0;
            n_reg         <= 4'd1;
            acc_reg       <= '0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rem_reg       <= rem_next;
            step_reg      <= step_next;
            wr_idx_reg    <= wr_idx_next;
            emit_idx_reg  <= emit_idx_next;
            n_reg         <= n_next;
            acc_reg       <= acc_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        out_reg  <= out_next;
        if (buf_we)
        begin
            buf_reg[buf_waddr] <= buf_wdata;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg < 7'(RADIX))
        else $error("division remainder out of range");

    a_emit_idx: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> 4'(emit_idx_reg) < n_reg)
        else $error("emit index beyond digit count");

    a_dec_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop && cmd.func == FUNC_DECODE && cmd.eos |=> acc_reg == '0 && !bad_reg)
        else $error("decode state not cleared after end of string");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.error_flag |-> out_reg.last_result)
        else $error("error result without last marker");

endmodule

### sv/base74_text_radix_codec_top.sv
// Channel   Direction  Handshake                 Payload
// item      in         push, full                in_item_t
// result    out        empty, pop                out_item_t
// config    in         cfg_we                    cfg_data (alphabet rotation)
//
// A decode request is absorbed by the back end and gives its result only on the end of a string.
// An encode request of n digits takes n-1 divisions by 74, each chunk by chunk in the 16-bit-chunk
// divider, then one range check and n emitted characters, or an error if the value is too large.
// A two-entry command queue lets new requests be accepted while the back end works or stalls.
// Reset clears the rotation, the decode accumulator, the queue pointers and the result valid flag.
module base74_text_radix_codec_top import b74_pkg::*; #(
    parameter int MAX_DIGITS = 10
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  in_item_t   item,
    output logic       empty,
    input  logic       pop,
    output out_item_t  result,
    input  logic       cfg_we,
    input  logic [6:0] cfg_data
);

    logic [6:0] rot_reg;
    logic [6:0] rot;
    logic       fifo_full;
    logic       cmd_push;
    cmd_t       cmd_in;
    logic       cmd_valid;
    logic       cmd_pop;
    cmd_t       cmd_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg <= '0;
        end
        else if (cfg_we)
        begin
            rot_reg <= cfg_data;
        end
    end

    assign rot = (rot_reg >= 7'(RADIX)) ? rot_reg - 7'(RADIX) : rot_reg;

    b74_front #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .push      (push),
        .item      (item),
        .rot       (rot),
        .fifo_full (fifo_full),
        .full      (full),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in)
    );

    b74_cmd_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_in),
        .full  (fifo_full),
        .pop   (cmd_pop),
        .valid (cmd_valid),
        .dout  (cmd_out)
    );

    b74_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rot       (rot),
        .cmd_valid (cmd_valid),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule
